>>> hw/rtl/sosa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sosa_pkg
// Shared types and constants of the slab object slot allocator.
// ----------------------------------------------------------------------------
package sosa_pkg;

   // Default storage sizes
   localparam int SLAB_MAX_DEF  = 16;
   localparam int SLOTS_MAX_DEF = 64;

   // Field and register widths, and the objects_per_slab reset value
   localparam int OPS_W      = 7;
   localparam int LIM_W      = 5;
   localparam int REL_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int OPS_RESET  = 64;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_SHRINK = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_NO_SLAB   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TAG_UNUSED  = 2'd0,
      TAG_EMPTY   = 2'd1,
      TAG_PARTIAL = 2'd2,
      TAG_FULL    = 2'd3
   } tag_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OBJECTS = 1'b0,
      REG_LIMIT   = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PICK,
      S_SLOT,
      S_FREE,
      S_SHRINK,
      S_UNLINK,
      S_PUSH,
      S_RESP
   } fsm_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] slab_index;
      logic [5:0] slot_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [3:0]       granted_slab;
      logic [5:0]       granted_slot;
      logic [REL_W-1:0] released_count;
   } rsp_word_type;

endpackage

>>> hw/rtl/sosa_ffs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sosa_ffs
// Shared find-first unit: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module sosa_ffs #(
   parameter int W = 64
) (
   input  logic [W-1:0]                    vec,
   output logic                            found,
   output logic [((W > 1) ? $clog2(W) : 1)-1:0] idx
);

   localparam int IW = (W > 1) ? $clog2(W) : 1;

   // Scan from the top so the lowest set bit wins
   always_comb begin
      found = 1'b0;
      idx   = '0;
      for (int i = W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            found = 1'b1;
            idx   = IW'(i);
         end
      end
   end

endmodule

>>> hw/rtl/slab_object_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_slot_allocator
// Slab allocator for one cache: slot bitmaps, free counts and three LIFO lists.
// ----------------------------------------------------------------------------
// One command at a time: start is taken when busy is low, and the response
// word shows on rsp_data for exactly one cycle with rsp_valid high; the
// receiver cannot stall it. An alloc runs the pick state, then the slot
// state if a slab is found; a free runs the free state; either adds unlink
// and push when the slab changes list. A shrink runs one unlink per released
// slab; a no-op goes straight to the response. busy drops in the cycle after
// the strobe. A small sequencer runs these steps, one list-link operation per
// cycle, and shares one find-first unit between the lowest-unused-record search
// and the lowest-free-slot search. No clearing pass is needed after reset.
module slab_object_slot_allocator #(
   parameter int SLAB_MAX  = sosa_pkg::SLAB_MAX_DEF,
   parameter int SLOTS_MAX = sosa_pkg::SLOTS_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  sosa_pkg::req_word_type                req_data,
   output logic                                  rsp_valid,
   output sosa_pkg::rsp_word_type                rsp_data,
   input  logic                                  csr_we,
   input  logic [sosa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sosa_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SLAB_IW = $clog2(SLAB_MAX + 1);
   localparam int SLAB_AW = (SLAB_MAX > 1) ? $clog2(SLAB_MAX) : 1;
   localparam int SLOT_IW = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
   localparam int FFS_W   = (SLOTS_MAX > SLAB_MAX) ? SLOTS_MAX : SLAB_MAX;
   localparam int FFS_IW  = (FFS_W > 1) ? $clog2(FFS_W) : 1;
   localparam int OPS_W   = sosa_pkg::OPS_W;
   localparam int REL_W   = sosa_pkg::REL_W;
   localparam logic [SLAB_IW-1:0] NIL = SLAB_IW'(SLAB_MAX);
   localparam logic [OPS_W-1:0] OPS_INIT =
      OPS_W'((sosa_pkg::OPS_RESET > SLOTS_MAX) ? SLOTS_MAX : sosa_pkg::OPS_RESET);

   // Control and configuration
   sosa_pkg::fsm_state_type state_ff, state_in;
   sosa_pkg::tag_type       tgt_ff;
   sosa_pkg::status_type    status_ff;
   logic [5:0]              kidx_ff;
   logic                    sidx_ok_ff;
   logic [SLAB_IW-1:0]      cur_ff;
   logic [3:0]              gslab_ff;
   logic [5:0]              gslot_ff;
   logic [REL_W-1:0]        rel_ff;
   logic [OPS_W-1:0]        ops_ff;
   logic [sosa_pkg::LIM_W-1:0] lim_ff;

   // Slab records
   logic [SLOTS_MAX-1:0] bitmap_ff [SLAB_MAX];
   logic [OPS_W-1:0]     free_ff   [SLAB_MAX];
   sosa_pkg::tag_type    tag_ff    [SLAB_MAX];
   logic [SLAB_IW-1:0]   next_ff   [SLAB_MAX];
   logic [SLAB_IW-1:0]   prev_ff   [SLAB_MAX];
   logic [SLAB_IW-1:0]   ehead_ff, phead_ff, fhead_ff;

   // Combinational helpers
   logic [SLAB_AW-1:0]   cur_idx;
   logic [SLOTS_MAX-1:0] slot_mask;
   logic [SLOTS_MAX-1:0] free_vec;
   logic [SLAB_MAX-1:0]  unused_vec;
   logic [FFS_W-1:0]     ffs_vec;
   logic                 ffs_found;
   logic [FFS_IW-1:0]    ffs_idx;
   logic                 any_use;
   logic                 accept;
   logic                 kidx_ok;
   logic                 bit_set;
   logic                 slab_live;
   logic                 free_ok;
   logic [OPS_W-1:0]     free_dec, free_inc;
   logic [SLAB_IW-1:0]   alloc_src;
   logic [SLAB_IW-1:0]   push_head;
   logic [SLAB_IW-1:0]   ul_prev, ul_next;
   logic [OPS_W-1:0]     ops_wr;

   assign cur_idx  = cur_ff[SLAB_AW-1:0];
   assign accept   = start && (state_ff == sosa_pkg::S_IDLE);
   assign free_dec = free_ff[cur_idx] - OPS_W'(1);
   assign free_inc = free_ff[cur_idx] + OPS_W'(1);
   assign alloc_src = (phead_ff != NIL) ? phead_ff : ehead_ff;
   assign ul_prev  = prev_ff[cur_idx];
   assign ul_next  = next_ff[cur_idx];
   assign kidx_ok  = (OPS_W'(kidx_ff) < ops_ff);
   assign bit_set  = bitmap_ff[cur_idx][SLOT_IW'(kidx_ff)];
   // A free only touches a slab on the partial or full list
   assign slab_live = sidx_ok_ff && (tag_ff[cur_idx] == sosa_pkg::TAG_PARTIAL ||
                                     tag_ff[cur_idx] == sosa_pkg::TAG_FULL);
   assign free_ok   = slab_live && kidx_ok && bit_set;

   // Build masks for the shared find-first unit
   always_comb begin
      any_use = 1'b0;
      for (int r = 0; r < SLAB_MAX; r++) begin
         any_use = any_use | (tag_ff[r] != sosa_pkg::TAG_UNUSED);
         unused_vec[r] = (tag_ff[r] == sosa_pkg::TAG_UNUSED) &&
                         ((r < int'(lim_ff)) || (r == 0));
      end
      for (int k = 0; k < SLOTS_MAX; k++) begin
         slot_mask[k] = (k < int'(ops_ff));
      end
      free_vec = ~bitmap_ff[cur_idx] & slot_mask;
      ffs_vec  = '0;
      if (state_ff == sosa_pkg::S_PICK) begin
         ffs_vec[SLAB_MAX-1:0] = unused_vec;
      end else begin
         ffs_vec[SLOTS_MAX-1:0] = free_vec;
      end
   end

   sosa_ffs #(.W(FFS_W)) u_ffs (
      .vec   (ffs_vec),
      .found (ffs_found),
      .idx   (ffs_idx)
   );

   // Select the head a push goes to
   always_comb begin
      case (tgt_ff)
         sosa_pkg::TAG_EMPTY:   push_head = ehead_ff;
         sosa_pkg::TAG_PARTIAL: push_head = phead_ff;
         default:               push_head = fhead_ff;
      endcase
   end

   // Clamp objects_per_slab writes
   always_comb begin
      ops_wr = csr_wdata[OPS_W-1:0];
      if (ops_wr == '0) begin
         ops_wr = OPS_W'(1);
      end else if (int'(ops_wr) > SLOTS_MAX) begin
         ops_wr = OPS_W'(SLOTS_MAX);
      end
   end

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sosa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sosa_pkg::S_IDLE: begin
            if (start) begin
               case (sosa_pkg::cmd_type'(req_data.command))
                  sosa_pkg::CMD_ALLOC:  state_in = sosa_pkg::S_PICK;
                  sosa_pkg::CMD_FREE:   state_in = sosa_pkg::S_FREE;
                  sosa_pkg::CMD_SHRINK: state_in = sosa_pkg::S_SHRINK;
                  default:              state_in = sosa_pkg::S_RESP;
               endcase
            end
         end
         sosa_pkg::S_PICK: begin
            if (ehead_ff == NIL && phead_ff == NIL && !ffs_found) begin
               state_in = sosa_pkg::S_RESP;
            end else begin
               state_in = sosa_pkg::S_SLOT;
            end
         end
         sosa_pkg::S_SLOT: begin
            if (!ffs_found || free_ff[cur_idx] == '0) begin
               state_in = sosa_pkg::S_RESP;
            end else if (free_dec == '0 || tag_ff[cur_idx] == sosa_pkg::TAG_EMPTY) begin
               state_in = sosa_pkg::S_UNLINK;
            end else begin
               state_in = sosa_pkg::S_RESP;
            end
         end
         sosa_pkg::S_FREE: begin
            if (!free_ok) begin
               state_in = sosa_pkg::S_RESP;
            end else if (free_inc >= ops_ff || tag_ff[cur_idx] == sosa_pkg::TAG_FULL) begin
               state_in = sosa_pkg::S_UNLINK;
            end else begin
               state_in = sosa_pkg::S_RESP;
            end
         end
         sosa_pkg::S_SHRINK: begin
            state_in = (ehead_ff != NIL) ? sosa_pkg::S_UNLINK : sosa_pkg::S_RESP;
         end
         sosa_pkg::S_UNLINK: begin
            state_in = (tgt_ff == sosa_pkg::TAG_UNUSED) ? sosa_pkg::S_SHRINK
                                                        : sosa_pkg::S_PUSH;
         end
         sosa_pkg::S_PUSH: state_in = sosa_pkg::S_RESP;
         sosa_pkg::S_RESP: state_in = sosa_pkg::S_IDLE;
         default:          state_in = sosa_pkg::S_IDLE;
      endcase
   end

   // Hold configuration; objects_per_slab is frozen while any slab exists
   always_ff @(posedge clock) begin
      if (reset) begin
         ops_ff <= OPS_INIT;
         lim_ff <= sosa_pkg::LIM_W'(16);
      end else if (csr_we) begin
         case (sosa_pkg::reg_index_type'(csr_index))
            sosa_pkg::REG_OBJECTS: begin
               if (!any_use) ops_ff <= ops_wr;
            end
            sosa_pkg::REG_LIMIT: lim_ff <= csr_wdata[sosa_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // List heads and tags
   always_ff @(posedge clock) begin
      if (reset) begin
         ehead_ff <= NIL;
         phead_ff <= NIL;
         fhead_ff <= NIL;
         for (int r = 0; r < SLAB_MAX; r++) tag_ff[r] <= sosa_pkg::TAG_UNUSED;
      end else begin
         case (state_ff)
            sosa_pkg::S_PICK: begin
               // create a slab on the empty list (that list is empty here)
               if (ehead_ff == NIL && phead_ff == NIL && ffs_found) begin
                  ehead_ff <= SLAB_IW'(ffs_idx);
                  tag_ff[SLAB_AW'(ffs_idx)] <= sosa_pkg::TAG_EMPTY;
               end
            end
            sosa_pkg::S_UNLINK: begin
               if (ul_prev == NIL) begin
                  case (tag_ff[cur_idx])
                     sosa_pkg::TAG_EMPTY:   ehead_ff <= ul_next;
                     sosa_pkg::TAG_PARTIAL: phead_ff <= ul_next;
                     default:               fhead_ff <= ul_next;
                  endcase
               end
               tag_ff[cur_idx] <= sosa_pkg::TAG_UNUSED;
            end
            sosa_pkg::S_PUSH: begin
               case (tgt_ff)
                  sosa_pkg::TAG_EMPTY:   ehead_ff <= cur_ff;
                  sosa_pkg::TAG_PARTIAL: phead_ff <= cur_ff;
                  default:               fhead_ff <= cur_ff;
               endcase
               tag_ff[cur_idx] <= tgt_ff;
            end
            default: ;
         endcase
      end
   end

   // Record payload: bitmaps, counts, links
   always_ff @(posedge clock) begin
      case (state_ff)
         sosa_pkg::S_PICK: begin
            if (ehead_ff == NIL && phead_ff == NIL && ffs_found) begin
               bitmap_ff[SLAB_AW'(ffs_idx)] <= '0;
               free_ff[SLAB_AW'(ffs_idx)]   <= ops_ff;
               prev_ff[SLAB_AW'(ffs_idx)]   <= NIL;
               next_ff[SLAB_AW'(ffs_idx)]   <= NIL;
            end
         end
         sosa_pkg::S_SLOT: begin
            if (ffs_found && free_ff[cur_idx] != '0) begin
               bitmap_ff[cur_idx][SLOT_IW'(ffs_idx)] <= 1'b1;
               free_ff[cur_idx] <= free_dec;
            end
         end
         sosa_pkg::S_FREE: begin
            if (free_ok) begin
               bitmap_ff[cur_idx][SLOT_IW'(kidx_ff)] <= 1'b0;
               free_ff[cur_idx] <= free_inc;
            end
         end
         sosa_pkg::S_UNLINK: begin
            if (ul_prev != NIL) next_ff[ul_prev[SLAB_AW-1:0]] <= ul_next;
            if (ul_next != NIL) prev_ff[ul_next[SLAB_AW-1:0]] <= ul_prev;
         end
         sosa_pkg::S_PUSH: begin
            prev_ff[cur_idx] <= NIL;
            next_ff[cur_idx] <= push_head;
            if (push_head != NIL) prev_ff[push_head[SLAB_AW-1:0]] <= cur_ff;
         end
         default: ;
      endcase
   end

   // Command word, current slab and response fields
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= sosa_pkg::TAG_UNUSED;
      end else begin
         case (state_ff)
            sosa_pkg::S_IDLE: begin
               if (accept) begin
                  kidx_ff    <= req_data.slot_index;
                  sidx_ok_ff <= (int'(req_data.slab_index) < SLAB_MAX);
                  cur_ff     <= SLAB_IW'(req_data.slab_index);
                  tgt_ff     <= sosa_pkg::TAG_UNUSED;
                  status_ff  <= sosa_pkg::ST_OK;
                  gslab_ff   <= '0;
                  gslot_ff   <= '0;
                  rel_ff     <= '0;
               end
            end
            sosa_pkg::S_PICK: begin
               if (ehead_ff == NIL && phead_ff == NIL) begin
                  if (ffs_found) cur_ff <= SLAB_IW'(ffs_idx);
                  else           status_ff <= sosa_pkg::ST_NO_SPACE;
               end else begin
                  cur_ff <= alloc_src;
               end
            end
            sosa_pkg::S_SLOT: begin
               if (!ffs_found || free_ff[cur_idx] == '0) begin
                  status_ff <= sosa_pkg::ST_NO_SPACE;
               end else begin
                  gslab_ff <= 4'(cur_ff);
                  gslot_ff <= 6'(ffs_idx);
                  tgt_ff   <= (free_dec == '0) ? sosa_pkg::TAG_FULL : sosa_pkg::TAG_PARTIAL;
               end
            end
            sosa_pkg::S_FREE: begin
               if (!slab_live) begin
                  status_ff  <= sosa_pkg::ST_NO_SLAB;
                  sidx_ok_ff <= 1'b0;
               end else if (!kidx_ok || !bit_set) begin
                  status_ff <= sosa_pkg::ST_NOT_ALLOC;
               end else begin
                  tgt_ff <= (free_inc >= ops_ff) ? sosa_pkg::TAG_EMPTY : sosa_pkg::TAG_PARTIAL;
               end
            end
            sosa_pkg::S_SHRINK: begin
               if (ehead_ff != NIL) begin
                  cur_ff <= ehead_ff;
                  if (rel_ff != '1) rel_ff <= rel_ff + REL_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // Drive the ports
   assign busy      = (state_ff != sosa_pkg::S_IDLE);
   assign rsp_valid = (state_ff == sosa_pkg::S_RESP);
   always_comb begin
      rsp_data.status         = status_ff;
      rsp_data.granted_slab   = gslab_ff;
      rsp_data.granted_slot   = gslot_ff;
      rsp_data.released_count = rel_ff;
   end

endmodule

>>> hw/rtl/sosa_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sosa_check
// Port-level checks of the slab allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sosa_check (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input sosa_pkg::rsp_word_type rsp_data
);

   // A taken command occupies the block
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after a taken command");

   // A response only ends a running command
   a_resp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response word while idle");

   // One response word per command
   a_single_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // Failed commands carry no grant and no release count
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != sosa_pkg::ST_OK |->
         rsp_data.granted_slab == '0 && rsp_data.granted_slot == '0 &&
         rsp_data.released_count == '0)
      else $error("failed command reports a grant");

endmodule

bind slab_object_slot_allocator sosa_check u_sosa_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
